// ===== rtl/hadd_pkg.sv =====
// Shared constants, command codes and interface structs for the Hebbian AQM drop decider.
// Used by hadd_ctrl, hadd_datapath and the top level; depends on nothing else.
`default_nettype none

package hadd_pkg;

  // History depth and the derived vector sizes.
  localparam int DELAY_STEPS = 10;
  localparam int NUM_W       = DELAY_STEPS + 3;
  localparam int NUM_C       = DELAY_STEPS + 1;
  localparam int IDX_W       = $clog2(NUM_W);

  // Field and datapath widths.
  localparam int QLEN_W  = 10;
  localparam int RND_W   = 16;
  localparam int LR_W    = 24;
  localparam int ERR_W   = 11;
  localparam int PROB_W  = 16;
  localparam int W_W     = 18;
  localparam int PIV_W   = 17;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 50;
  localparam int G_W     = 24;
  localparam int HEB_W   = 36;
  localparam int WSUM_W  = 48;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 24;

  // Fixed-point constants.
  localparam int WEIGHT_ONE   = 65536;
  localparam int WEIGHT_INIT  = 655;
  localparam int PROB_MAX     = 65535;
  localparam int TARGET_RESET = 500;
  localparam int LR_RESET     = 16777;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_TARGET  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = CFG_IDX_W'(1);

  // Sequencer schedule: gain, Hebbian factor, dot product pass, weight update pass.
  localparam int STEP_G    = 0;
  localparam int STEP_H    = 2;
  localparam int STEP_DOT  = 3;
  localparam int STEP_UPD  = STEP_DOT + NUM_W;
  localparam int STEP_LAST = STEP_UPD + NUM_W;
  localparam int STEP_W    = $clog2(STEP_LAST + 1);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_G,
    OP_H,
    OP_DOT,
    OP_UPD
  } mul_op_e;

  typedef struct packed {
    logic             load;
    logic             cfg_write;
    mul_op_e          op;
    logic [IDX_W-1:0] idx;
    logic             finish;
  } hadd_cmd_t;

  typedef struct packed {
    logic out_stall;
  } hadd_status_t;

endpackage

`default_nettype wire

// ===== rtl/hadd_ctrl.sv =====
// Sequencer for the Hebbian AQM drop decider: issues an arrival's multiplier operations in turn, one arrival at a time.
// Depends on hadd_pkg for the schedule constants and the command and status structs.
`default_nettype none

module hadd_ctrl import hadd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  output hadd_cmd_t         cmd_o,
  input  wire hadd_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              in_ready_q;
  logic [STEP_W-1:0] dot_off;
  logic [STEP_W-1:0] upd_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      in_ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && !cfg_valid_i) begin
            state_q    <= ST_RUN;
            step_q     <= '0;
            in_ready_q <= 1'b0;
          end
        end
        ST_RUN: begin
          if (step_q == STEP_W'(STEP_LAST)) begin
            state_q <= ST_FINISH;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_FINISH: begin
          // The result register must be free before the new result is written.
          if (!status_i.out_stall) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= ST_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign dot_off = step_q - STEP_W'(STEP_DOT);
  assign upd_off = step_q - STEP_W'(STEP_UPD);

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_NONE;
    // A register write takes precedence over an arrival offered in the same cycle.
    cmd_o.load      = in_valid_i && in_ready_q && !cfg_valid_i;
    cmd_o.cfg_write = cfg_valid_i && in_ready_q;
    cmd_o.finish    = (state_q == ST_FINISH) && !status_i.out_stall;
    if (state_q == ST_RUN) begin
      if (step_q == STEP_W'(STEP_G)) begin
        cmd_o.op = OP_G;
      end else if (step_q == STEP_W'(STEP_H)) begin
        cmd_o.op = OP_H;
      end else if (step_q >= STEP_W'(STEP_DOT) && step_q < STEP_W'(STEP_UPD)) begin
        cmd_o.op  = OP_DOT;
        cmd_o.idx = dot_off[IDX_W-1:0];
      end else if (step_q >= STEP_W'(STEP_UPD) && step_q < STEP_W'(STEP_LAST)) begin
        cmd_o.op  = OP_UPD;
        cmd_o.idx = upd_off[IDX_W-1:0];
      end
    end
  end

  assign in_ready_o  = in_ready_q && !cfg_valid_i;
  assign cfg_ready_o = in_ready_q;

  a_load_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_RUN && step_q == '0))
    else $error("accepted transaction did not start the sequence");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (!in_ready_q && !cmd_o.cfg_write && !cmd_o.load))
    else $error("transaction or register write taken while busy");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == STEP_W'(STEP_LAST)) |=> (state_q == ST_FINISH))
    else $error("sequence did not reach the finish state");

endmodule

`default_nettype wire

// ===== rtl/hadd_datapath.sv =====
// Datapath of the Hebbian AQM drop decider: state registers, shared multiplier,
// accumulator, weight update and result register. Depends on hadd_pkg.
`default_nettype none

module hadd_datapath import hadd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire hadd_cmd_t             cmd_i,
  output hadd_status_t               status_o,
  input  wire logic [QLEN_W-1:0]     queue_length_i,
  input  wire logic [RND_W-1:0]      random_value_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       drop_packet_o,
  output logic [PROB_W-1:0]          drop_probability_o
);

  localparam logic signed [WSUM_W-1:0] W_HI      = WSUM_W'(WEIGHT_ONE);
  localparam logic signed [WSUM_W-1:0] W_LO      = -W_HI;
  localparam logic signed [W_W-1:0]    W_HI_S    = W_W'(WEIGHT_ONE);
  localparam logic signed [W_W-1:0]    W_LO_S    = -W_HI_S;
  localparam logic signed [W_W-1:0]    W_INIT    = W_W'(WEIGHT_INIT);
  localparam logic signed [PROD_W-1:0] BIAS_ERR  = PROD_W'((1 << 8) - 1);
  localparam logic signed [PROD_W-1:0] BIAS_PROB = PROD_W'((1 << 24) - 1);

  logic [QLEN_W-1:0]        target_q;
  logic [LR_W-1:0]          lr_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [ERR_W-1:0]  last_err_q;
  logic signed [ERR_W-1:0]  prior_err_q;
  logic [PROB_W-1:0]        prior_ctl_q;
  logic [RND_W-1:0]         rnd_q;
  logic [PROB_W-1:0]        hist_q [NUM_C];
  logic signed [W_W-1:0]    w_q [NUM_W];
  logic signed [PIV_W-1:0]  piv_q [NUM_W];
  logic signed [PIV_W-1:0]  x_vec [NUM_W];
  logic signed [PIV_W-1:0]  x_sel;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;
  mul_op_e                   op_q;
  logic [IDX_W-1:0]          idx_q;

  logic [G_W-1:0]            g_q;
  logic signed [HEB_W-1:0]   h_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   dot_term;

  logic                      err_entry;
  logic signed [PROD_W-1:0]  p_adj;
  logic signed [PROD_W-1:0]  dw;
  logic signed [WSUM_W-1:0]  w_sum;
  logic signed [W_W-1:0]     w_new;

  logic [ERR_W-1:0]          err_new;
  logic [PROB_W-1:0]         prob_new;
  logic                      target_write;

  logic                      out_valid_q;
  logic                      out_drop_q;
  logic [PROB_W-1:0]         out_prob_q;

  assign target_write = cmd_i.cfg_write && (cfg_index_i == CFG_QUEUE_TARGET);
  assign err_new      = ERR_W'(queue_length_i) - ERR_W'(target_q);

  // Input vector: current error, previous error, then the probability history.
  always_comb begin
    x_vec[0] = PIV_W'(err_q);
    x_vec[1] = PIV_W'(last_err_q);
    for (int k = 0; k < NUM_C; k++) begin
      x_vec[k + 2] = PIV_W'(hist_q[k]);
    end
    x_sel = (cmd_i.idx < IDX_W'(NUM_W)) ? x_vec[cmd_i.idx] : '0;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_G: begin
        mul_a = MUL_A_W'(lr_q);
        mul_b = MUL_B_W'(prior_ctl_q);
      end
      OP_H: begin
        mul_a = MUL_A_W'(g_q);
        mul_b = MUL_B_W'(prior_err_q);
      end
      OP_DOT: begin
        mul_a = MUL_A_W'(w_q[0]);
        mul_b = MUL_B_W'(x_sel);
      end
      OP_UPD: begin
        mul_a = MUL_A_W'(h_q);
        mul_b = MUL_B_W'(piv_q[0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Error entries carry an extra factor of 2^16 in the sum and a shift of 8
  // in the update; probability entries use a shift of 24.
  assign err_entry = (idx_q < IDX_W'(2));
  assign dot_term  = err_entry ? {prod_q[ACC_W-17:0], 16'h0000} : prod_q[ACC_W-1:0];

  always_comb begin
    if (prod_q[PROD_W-1]) begin
      p_adj = prod_q + (err_entry ? BIAS_ERR : BIAS_PROB);
    end else begin
      p_adj = prod_q;
    end
    dw    = err_entry ? (p_adj >>> 8) : (p_adj >>> 24);
    w_sum = WSUM_W'(w_q[0]) + WSUM_W'(dw);
    if (w_sum > W_HI) begin
      w_new = W_HI_S;
    end else if (w_sum < W_LO) begin
      w_new = W_LO_S;
    end else begin
      w_new = w_sum[W_W-1:0];
    end
  end

  // Probability from the Q32 sum: zero when not positive, saturated at PROB_MAX.
  always_comb begin
    if (acc_q[ACC_W-1] || acc_q == '0) begin
      prob_new = '0;
    end else if (|acc_q[ACC_W-2:32]) begin
      prob_new = PROB_W'(PROB_MAX);
    end else begin
      prob_new = acc_q[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= QLEN_W'(TARGET_RESET);
      lr_q        <= LR_W'(LR_RESET);
      last_err_q  <= '0;
      prior_err_q <= '0;
      prior_ctl_q <= '0;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_C; k++) begin
        hist_q[k] <= '0;
      end
      for (int k = 0; k < NUM_W; k++) begin
        w_q[k]   <= W_INIT;
        piv_q[k] <= '0;
      end
    end else begin
      op_q <= cmd_i.op;

      if (cmd_i.cfg_write) begin
        unique case (cfg_index_i)
          CFG_QUEUE_TARGET:  target_q <= cfg_data_i[QLEN_W-1:0];
          CFG_LEARNING_RATE: lr_q     <= cfg_data_i[LR_W-1:0];
          default: ;
        endcase
      end

      // Weights form a ring read at its head; each pass turns it once.
      if (target_write) begin
        for (int k = 0; k < NUM_W; k++) begin
          w_q[k] <= w_q[k][W_W-1] ? -((-w_q[k]) >>> 1) : (w_q[k] >>> 1);
        end
      end else if (cmd_i.op == OP_DOT) begin
        for (int k = 0; k < NUM_W - 1; k++) begin
          w_q[k] <= w_q[k + 1];
        end
        w_q[NUM_W-1] <= w_q[0];
      end else if (op_q == OP_UPD) begin
        for (int k = 0; k < NUM_W - 1; k++) begin
          w_q[k] <= w_q[k + 1];
        end
        w_q[NUM_W-1] <= w_new;
      end

      if (cmd_i.op == OP_UPD) begin
        for (int k = 0; k < NUM_W - 1; k++) begin
          piv_q[k] <= piv_q[k + 1];
        end
        piv_q[NUM_W-1] <= piv_q[0];
      end else if (cmd_i.finish) begin
        for (int k = 0; k < NUM_W; k++) begin
          piv_q[k] <= x_vec[k];
        end
      end

      if (target_write) begin
        prior_err_q <= '0;
        prior_ctl_q <= '0;
      end else if (cmd_i.finish) begin
        prior_err_q <= err_q;
        prior_ctl_q <= prob_new;
      end

      if (cmd_i.finish) begin
        last_err_q <= err_q;
        hist_q[0]  <= prob_new;
        for (int k = 1; k < NUM_C; k++) begin
          hist_q[k] <= hist_q[k - 1];
        end
      end

      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    idx_q  <= cmd_i.idx;
    if (cmd_i.load) begin
      err_q <= err_new;
      rnd_q <= random_value_i;
      acc_q <= '0;
    end else if (op_q == OP_DOT) begin
      acc_q <= acc_q + dot_term;
    end
    if (op_q == OP_G) begin
      g_q <= prod_q[G_W+15:16];
    end
    if (op_q == OP_H) begin
      h_q <= prod_q[HEB_W-1:0];
    end
    if (cmd_i.finish) begin
      out_drop_q <= (rnd_q < prob_new);
      out_prob_q <= prob_new;
    end
  end

  assign status_o.out_stall  = out_valid_q && !out_ready_i;
  assign out_valid_o         = out_valid_q;
  assign drop_packet_o       = out_drop_q;
  assign drop_probability_o  = out_prob_q;

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_q[0] <= W_HI_S) && (w_q[0] >= W_LO_S))
    else $error("weight left the range of plus or minus one");

  a_finish_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("finished result not presented");

endmodule

`default_nettype wire

// ===== rtl/hebbian_aqm_drop_decider_core.sv =====
// Top level of the Hebbian AQM drop decider: joins the sequencer and the datapath.
// Depends on hadd_pkg, hadd_ctrl and hadd_datapath.
//
// Usage:
//   s_axis carries one packet arrival per transaction: queue length and a
//   uniform random fraction. m_axis returns one decision per arrival: the drop
//   flag and the new drop probability in Q0.16.
//   The cfg channel writes queue_target (index 0) and learning_rate (index 1);
//   other indexes are ignored. It is ready only while no arrival is in work,
//   and a write offered together with an arrival is taken first.
//   A target write halves all weights and clears the previous error and
//   probability terms.
// Timing:
//   One shared 36x18 multiplier does the gain, the Hebbian factor, 13 dot
//   product terms and 13 weight updates in turn. The result is registered
//   once the sequencer reaches its finish state, and the next arrival is
//   accepted only after the sequencer has returned to idle.
//   A result waits in the output register while the next arrival is worked
//   on; if the receiver still stalls when that one finishes, the sequencer
//   holds until the register is free.
// Reset:
//   Asynchronous, active low. Weights return to 0.01, histories to zero,
//   target to 500 and learning rate to about 0.001.
`default_nettype none

module hebbian_aqm_drop_decider_core import hadd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [9:0] queue_length, [25:10] random_value, [31:26] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [0] drop_packet, [16:1] drop_probability, [23:17] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  hadd_cmd_t         cmd;
  hadd_status_t      status;
  logic              drop_packet;
  logic [PROB_W-1:0] drop_probability;

  hadd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  hadd_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .queue_length_i     (s_axis_tdata_i[QLEN_W-1:0]),
    .random_value_i     (s_axis_tdata_i[QLEN_W+RND_W-1:QLEN_W]),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .drop_packet_o      (drop_packet),
    .drop_probability_o (drop_probability)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({drop_probability, drop_packet});

endmodule

`default_nettype wire

// ===== tb/hebbian_aqm_drop_decider_core_tb.sv =====
// Self-checking testbench for the Hebbian AQM drop decider core.
// Depends on hadd_pkg and hebbian_aqm_drop_decider_core; predicts every decision in place.
`timescale 1ns / 1ps

module hebbian_aqm_drop_decider_core_tb import hadd_pkg::*;;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;

  typedef enum logic {
    ITEM_ARRIVAL,
    ITEM_CFG
  } item_kind_e;

  typedef struct {
    item_kind_e            kind;
    logic [QLEN_W-1:0]     qlen;
    logic [RND_W-1:0]      rnd;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } pending_op_t;

  typedef struct packed {
    logic              drop;
    logic [PROB_W-1:0] prob;
  } decision_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_valid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  pending_op_t pending_ops[$];
  decision_t   decision_q[$];
  int          error_count = 0;
  int          cycle_count = 0;

  // Sender burst/gap and receiver stall pattern state.
  int burst_left = 1;
  int gap_left   = 0;
  int stall_mode = 0;
  int mode_left  = 0;

  // Predictor state.
  logic [QLEN_W-1:0]        tgt_q   = QLEN_W'(TARGET_RESET);
  logic [LR_W-1:0]          rate_q  = LR_W'(LR_RESET);
  logic signed [ERR_W-1:0]  last_err_q  = '0;
  logic signed [ERR_W-1:0]  prior_err_q = '0;
  logic [PROB_W-1:0]        prior_ctl_q = '0;
  logic [PROB_W-1:0]        ctl_hist_q [NUM_C];
  logic signed [W_W-1:0]    weight_q   [NUM_W];
  logic signed [PIV_W-1:0]  prior_vec_q[NUM_W];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hebbian_aqm_drop_decider_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Signed division by a power of two, truncated toward zero.
  function automatic longint shift_to_zero(longint v, int sh);
    if (v < 0) begin
      return -((-v) >>> sh);
    end
    return v >>> sh;
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_QUEUE_TARGET: begin
        tgt_q = data[QLEN_W-1:0];
        for (int i = 0; i < NUM_W; i++) begin
          weight_q[i] = W_W'(shift_to_zero(longint'(weight_q[i]), 1));
        end
        prior_err_q = '0;
        prior_ctl_q = '0;
      end
      CFG_LEARNING_RATE: begin
        rate_q = data[LR_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Computes the decision for one arrival and advances the learning state.
  function automatic decision_t decide_arrival(logic [QLEN_W-1:0] qlen,
                                               logic [RND_W-1:0] rnd);
    logic signed [PIV_W-1:0] vec [NUM_W];
    logic signed [ERR_W-1:0] err;
    logic [PROB_W-1:0]       prob;
    longint                  acc;
    longint                  gain;
    longint                  prod;
    longint                  w;
    int                      diff;
    decision_t               d;
    diff = int'(qlen) - int'(tgt_q);
    err  = diff[ERR_W-1:0];
    vec[0] = err;
    vec[1] = last_err_q;
    for (int i = 0; i < NUM_C; i++) begin
      vec[i+2] = {1'b0, ctl_hist_q[i]};
    end
    acc = 0;
    for (int i = 0; i < NUM_W; i++) begin
      if (i < 2) begin
        acc += longint'(weight_q[i]) * longint'(vec[i]) * 65536;
      end else begin
        acc += longint'(weight_q[i]) * longint'(vec[i]);
      end
    end
    if (acc <= 0) begin
      prob = '0;
    end else if ((acc >>> 16) > PROB_MAX) begin
      prob = PROB_W'(PROB_MAX);
    end else begin
      prob = PROB_W'(acc >>> 16);
    end
    gain = (longint'(rate_q) * longint'(prior_ctl_q)) >>> 16;
    for (int i = 0; i < NUM_W; i++) begin
      prod = gain * longint'(prior_err_q) * longint'(prior_vec_q[i]);
      w = longint'(weight_q[i]) + shift_to_zero(prod, (i < 2) ? 8 : 24);
      if (w > WEIGHT_ONE) w = WEIGHT_ONE;
      if (w < -WEIGHT_ONE) w = -WEIGHT_ONE;
      weight_q[i] = W_W'(w);
    end
    prior_err_q = err;
    prior_ctl_q = prob;
    for (int i = 0; i < NUM_W; i++) begin
      prior_vec_q[i] = vec[i];
    end
    last_err_q = err;
    for (int i = NUM_C - 1; i > 0; i--) begin
      ctl_hist_q[i] = ctl_hist_q[i-1];
    end
    ctl_hist_q[0] = prob;
    d.drop = (rnd < prob);
    d.prob = prob;
    return d;
  endfunction

  task automatic add_arrival(int qlen, int rnd);
    pending_op_t op;
    op.kind = ITEM_ARRIVAL;
    op.qlen = QLEN_W'(qlen);
    op.rnd  = RND_W'(rnd);
    op.idx  = '0;
    op.data = '0;
    pending_ops = {pending_ops, op};
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int data);
    pending_op_t op;
    op.kind = ITEM_CFG;
    op.qlen = '0;
    op.rnd  = '0;
    op.idx  = idx;
    op.data = CFG_DATA_W'(data);
    pending_ops = {pending_ops, op};
  endtask

  // Driver: arrivals go out in bursts; a register write waits until every
  // outstanding decision has come back, which also drains the block.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic        in_fire;
    logic        cfg_fire;
    logic        next_valid;
    logic        next_cfg;
    int          r;
    pending_op_t op;
    if (!rst_ni) begin
      s_valid   <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      in_fire  = s_valid && s_tready;
      cfg_fire = cfg_valid && cfg_ready;
      if (in_fire) begin
        decision_q = {decision_q, decide_arrival(s_tdata[QLEN_W-1:0],
                                                 s_tdata[QLEN_W+RND_W-1:QLEN_W])};
      end
      if (cfg_fire) begin
        write_register(cfg_index, cfg_data);
      end
      next_valid = s_valid && !in_fire;
      next_cfg   = cfg_valid && !cfg_fire;
      if (!next_valid && !next_cfg && pending_ops.size() > 0) begin
        if (pending_ops[0].kind == ITEM_CFG) begin
          if (decision_q.size() == 0) begin
            op = pending_ops.pop_front();
            cfg_index <= op.idx;
            cfg_data  <= op.data;
            next_cfg = 1'b1;
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          op = pending_ops.pop_front();
          s_tdata <= IN_TDATA_W'({op.rnd, op.qlen});
          next_valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            r = $urandom_range(0, 9);
            if (r < 4) begin
              gap_left = 0;
            end else if (r < 8) begin
              gap_left = $urandom_range(1, 8);
            end else begin
              gap_left = $urandom_range(20, 60);
            end
          end
        end
      end
      s_valid   <= next_valid;
      cfg_valid <= next_cfg;
    end
  end

  // Monitor: checks each decision transaction and drives the stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    decision_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (decision_q.size() == 0) begin
          $error("unexpected decision transaction: tdata %h", m_tdata);
          error_count++;
        end else begin
          want = decision_q.pop_front();
          if (m_tdata[0] !== want.drop) begin
            $error("drop_packet mismatch: expected %0d, actual %0d", want.drop, m_tdata[0]);
            error_count++;
          end
          if (m_tdata[PROB_W:1] !== want.prob) begin
            $error("drop_probability mismatch: expected %0d, actual %0d",
                   want.prob, m_tdata[PROB_W:1]);
            error_count++;
          end
        end
      end
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= ($urandom_range(0, 7) == 0);
        default: m_tready <= (mode_left % 64 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** hebbian_aqm_drop_decider_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int t;
    int v;
    int r;
    for (int i = 0; i < NUM_C; i++) ctl_hist_q[i] = '0;
    for (int i = 0; i < NUM_W; i++) begin
      weight_q[i]    = W_W'(WEIGHT_INIT);
      prior_vec_q[i] = '0;
    end

    // Directed part. A full queue right after reset raises the probability
    // below saturation, and random_value 65535 still leaves that packet enqueued.
    add_arrival(0, 0);
    add_arrival(1023, 65535);
    add_arrival(1023, 0);
    add_arrival(500, 12345);
    add_arrival(0, 65535);
    add_cfg(CFG_QUEUE_TARGET, 1000);
    add_arrival(1023, 0);
    add_arrival(0, 100);
    // Target zero lies outside the nominal range but is accepted.
    add_cfg(CFG_QUEUE_TARGET, 0);
    add_arrival(0, 0);
    add_arrival(1023, 65535);
    add_cfg(CFG_QUEUE_TARGET, 1023);
    add_arrival(1023, 1);
    add_arrival(512, 40000);
    add_cfg(CFG_QUEUE_TARGET, 1);
    add_cfg(CFG_LEARNING_RATE, 'hFFFFFF);
    add_arrival(1, 0);
    add_arrival(1023, 65535);
    add_arrival(700, 32768);
    add_arrival(2, 1);
    add_cfg(CFG_LEARNING_RATE, 0);
    add_arrival(600, 0);
    // Writes to unknown register indexes are ignored.
    add_cfg(CFG_IDX_W'(2), 'h5A5A5A);
    add_cfg(CFG_IDX_W'(255), 'hFFFFFF);
    add_arrival(300, 500);
    add_cfg(CFG_QUEUE_TARGET, TARGET_RESET);
    add_cfg(CFG_LEARNING_RATE, LR_RESET);
    add_arrival(520, 20000);

    // Random phases, each under a fresh setting of both registers.
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       t = 0;
        1:       t = 1;
        2:       t = 1000;
        3:       t = 1023;
        default: t = $urandom_range(1, 1000);
      endcase
      case ($urandom_range(0, 4))
        0:       v = 0;
        1:       v = 'hFFFFFF;
        2:       v = LR_RESET;
        default: v = $urandom_range(0, 'hFFFFFF);
      endcase
      if ($urandom_range(0, 1)) begin
        add_cfg(CFG_QUEUE_TARGET, t);
        add_cfg(CFG_LEARNING_RATE, v);
      end else begin
        add_cfg(CFG_LEARNING_RATE, v);
        add_cfg(CFG_QUEUE_TARGET, t);
      end
      if ($urandom_range(0, 2) == 0) begin
        add_cfg(CFG_IDX_W'($urandom_range(2, 255)), $urandom_range(0, 'hFFFFFF));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          v = t + int'($urandom_range(0, 100)) - 50;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
        end else if (r < 8) begin
          v = $urandom_range(0, 1023);
        end else begin
          v = $urandom_range(0, 1) ? 1023 : 0;
        end
        r = $urandom_range(0, 19);
        if (r == 0) begin
          add_arrival(v, 0);
        end else if (r == 1) begin
          add_arrival(v, 65535);
        end else begin
          add_arrival(v, $urandom_range(0, 65535));
        end
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() > 0 || s_valid || cfg_valid || decision_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** hebbian_aqm_drop_decider_core: PASSED **");
    end else begin
      $display("** hebbian_aqm_drop_decider_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hadd_pkg.sv
rtl/hadd_ctrl.sv
rtl/hadd_datapath.sv
rtl/hebbian_aqm_drop_decider_core.sv
tb/hebbian_aqm_drop_decider_core_tb.sv
